// ----- design/ldg_pkg.sv -----
package ldg_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 11;
   localparam int DENSITY_W  = 16;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DIFFUSION_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT    = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd8192;
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd64;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd64;
   localparam logic [SIZE_W-1:0] SIZE_MIN     = 11'd3;

   typedef struct packed {
      logic [DENSITY_W-1:0] new_density;
      logic [COL_W-1:0]     cell_x;
      logic [ROW_W-1:0]     cell_y;
      logic                 last_of_run;
   } result_type;

endpackage

// ----- design/laplacian_diffusion_grid.sv -----
// Channel | Direction | Signals                                         | Beat
// req     | in        | req_valid, req_ready, req_density               | one grid sample
// rsp     | out       | rsp_valid, rsp_ready, rsp_new_density, rsp_cell_x,
//         |           | rsp_cell_y, rsp_last_of_run                     | one diffused cell
// csr     | in        | csr_write_enable, csr_index, csr_write_data     | one register write
//
// One sample is accepted per cycle unless the prefetch reloads or the queue is nearly
// full; its results pass through the stage register and then the result queue.
// Samples of the last row give two results each, so there the output port holds back
// the input. The line buffer is a single memory with one write and one read port; the
// read prefetches two columns ahead. After reset and after every register write, the
// prefetch reloads in PRIME_START and PRIME_NEXT before req_ready rises. Results wait
// in a four-entry queue; a stalled rsp side stops input only once it is nearly full.
module laplacian_diffusion_grid
   import ldg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DENSITY_W-1:0]  req_density,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DENSITY_W-1:0]  rsp_new_density,
   output logic [COL_W-1:0]      rsp_cell_x,
   output logic [ROW_W-1:0]      rsp_cell_y,
   output logic                  rsp_last_of_run,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam logic [SIZE_W-1:0] WIDTH_MAX  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_MAX = SIZE_W'(MAX_HEIGHT);
   localparam logic [1:0] PRIME_START = 2'd2;
   localparam logic [1:0] PRIME_NEXT  = 2'd1;
   localparam logic [1:0] PRIME_DONE  = 2'd0;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // Configuration registers
   logic [GAIN_W-1:0] gain_ff;
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DIFFUSION_GAIN: gain_ff   <= csr_write_data[GAIN_W-1:0];
            CSR_GRID_WIDTH:     width_ff  <= csr_write_data[SIZE_W-1:0];
            CSR_GRID_HEIGHT:    height_ff <= csr_write_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   logic [SIZE_W-1:0] w_eff;
   logic [SIZE_W-1:0] h_eff;

   assign w_eff = (width_ff < SIZE_MIN) ? SIZE_MIN :
                  (width_ff > WIDTH_MAX) ? WIDTH_MAX : width_ff;
   assign h_eff = (height_ff < SIZE_MIN) ? SIZE_MIN :
                  (height_ff > HEIGHT_MAX) ? HEIGHT_MAX : height_ff;

   // Raster position and neighbor registers
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [DENSITY_W-1:0]   left_ff;
   logic [2*DENSITY_W-1:0] cur_ff;
   logic [2*DENSITY_W-1:0] rd_data_ff;
   logic [1:0]             prime_ff, prime_in;

   logic [COL_W-1:0] x, x1, x2;
   logic [ROW_W-1:0] y;
   logic             accept;
   logic             s1_advance;

   assign x  = ({1'b0, col_ff} >= w_eff) ? '0 : col_ff;
   assign y  = ({1'b0, row_ff} >= h_eff) ? '0 : row_ff;
   assign x1 = ({1'b0, x} + 1'b1 >= w_eff) ? '0 : x + 1'b1;
   assign x2 = ({1'b0, x1} + 1'b1 >= w_eff) ? '0 : x1 + 1'b1;

   assign accept = req_valid && req_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = x1;
         if (x1 == '0) begin
            row_in = ({1'b0, y} + 1'b1 >= h_eff) ? '0 : y + 1'b1;
         end else begin
            row_in = y;
         end
      end
   end

   always_comb begin
      prime_in = prime_ff;
      if (csr_write_enable) begin
         prime_in = PRIME_START;
      end else if (prime_ff != PRIME_DONE) begin
         prime_in = prime_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
         prime_ff <= PRIME_START;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         prime_ff <= prime_in;
         if (accept) begin
            left_ff <= cur_ff[2*DENSITY_W-1:DENSITY_W];
         end
      end
   end

   // Line buffer: upper half is the row above, lower half the row two above.
   // The read runs two columns ahead of the input, so cur_ff holds this
   // column and rd_data_ff the column to its right when a sample arrives.
   logic [2*DENSITY_W-1:0] lb_mem [MAX_WIDTH];
   logic                   rd_en;
   logic [COL_W-1:0]       rd_addr;

   assign rd_en   = accept || (prime_ff != PRIME_DONE);
   assign rd_addr = accept ? x2 : ((prime_ff == PRIME_START) ? x : x1);

   always_ff @(posedge clock) begin
      if (accept) begin
         lb_mem[x] <= {req_density, cur_ff[2*DENSITY_W-1:DENSITY_W]};
      end
      if (rd_en) begin
         rd_data_ff <= lb_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept || (prime_ff == PRIME_NEXT)) begin
         cur_ff <= rd_data_ff;
      end
   end

   // Laplacian stage
   logic [DENSITY_W-1:0] centre, up, right;
   logic [DENSITY_W+1:0] sum4;
   logic signed [DENSITY_W+2:0] lap;
   logic last_row;

   assign centre   = cur_ff[2*DENSITY_W-1:DENSITY_W];
   assign up       = cur_ff[DENSITY_W-1:0];
   assign right    = rd_data_ff[2*DENSITY_W-1:DENSITY_W];
   assign sum4     = (DENSITY_W+2)'(left_ff) + (DENSITY_W+2)'(right)
                   + (DENSITY_W+2)'(up) + (DENSITY_W+2)'(req_density);
   assign lap      = $signed({1'b0, sum4}) - $signed({1'b0, centre, 2'b00});
   assign last_row = ({1'b0, y} == h_eff - 1'b1);

   logic                        s1_valid_ff;
   logic signed [DENSITY_W+2:0] s1_lap_ff;
   logic [DENSITY_W-1:0]        s1_centre_ff;
   logic [DENSITY_W-1:0]        s1_density_ff;
   logic [COL_W-1:0]            s1_x_ff;
   logic [ROW_W-1:0]            s1_y_ff;
   logic                        s1_interior_ff;
   logic                        s1_has_first_ff;
   logic                        s1_has_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_lap_ff        <= lap;
         s1_centre_ff     <= centre;
         s1_density_ff    <= req_density;
         s1_x_ff          <= x;
         s1_y_ff          <= y;
         s1_interior_ff   <= (y > ROW_W'(1)) && (x != '0)
                             && ({1'b0, x} != w_eff - 1'b1);
         s1_has_first_ff  <= (y != '0);
         s1_has_second_ff <= last_row;
      end
   end

   // Gain multiply, round half up, clamp
   logic signed [GAIN_W:0]                 gain_s;
   logic signed [DENSITY_W+GAIN_W+3:0]     prod;
   logic signed [DENSITY_W+GAIN_W+3:0]     rounded;
   logic signed [DENSITY_W+4:0]            sum_c;
   logic [DENSITY_W-1:0]                   diffused;

   assign gain_s  = $signed({1'b0, gain_ff});
   assign prod    = s1_lap_ff * gain_s;
   assign rounded = prod + $signed((DENSITY_W+GAIN_W+4)'(32768));
   assign sum_c   = $signed({5'b0, s1_centre_ff})
                  + (DENSITY_W+5)'($signed(rounded[DENSITY_W+GAIN_W+3:GAIN_W]));

   always_comb begin
      if (sum_c < 0) begin
         diffused = '0;
      end else if (sum_c > $signed((DENSITY_W+5)'(65535))) begin
         diffused = '1;
      end else begin
         diffused = sum_c[DENSITY_W-1:0];
      end
   end

   result_type first_res, second_res;

   always_comb begin
      first_res.new_density  = s1_interior_ff ? diffused : s1_centre_ff;
      first_res.cell_x       = s1_x_ff;
      first_res.cell_y       = s1_y_ff - 1'b1;
      first_res.last_of_run  = !s1_has_second_ff;
      second_res.new_density = s1_density_ff;
      second_res.cell_x      = s1_x_ff;
      second_res.cell_y      = s1_y_ff;
      second_res.last_of_run = 1'b1;
   end

   // Result queue
   result_type         queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]    count_ff;
   logic               pop;
   logic [1:0]         push_n;

   // Two free entries cover the worst case of one stage entry.
   assign s1_advance = s1_valid_ff && (count_ff <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
   assign req_ready  = (prime_ff == PRIME_DONE) && (!s1_valid_ff || s1_advance);
   assign push_n     = s1_advance ? (2'(s1_has_first_ff) + 2'(s1_has_second_ff)) : 2'd0;
   assign rsp_valid  = (count_ff != '0);
   assign pop        = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QPTR_W'(push_n);
         rd_ptr_ff <= rd_ptr_ff + QPTR_W'(pop);
         count_ff  <= count_ff + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_has_first_ff) begin
         queue_ff[wr_ptr_ff] <= first_res;
      end
      if (s1_advance && s1_has_second_ff) begin
         queue_ff[wr_ptr_ff + 1'b1] <= second_res;
      end
   end

   result_type head;

   assign head            = queue_ff[rd_ptr_ff];
   assign rsp_new_density = head.new_density;
   assign rsp_cell_x      = head.cell_x;
   assign rsp_cell_y      = head.cell_y;
   assign rsp_last_of_run = head.last_of_run;

endmodule

// ----- design/ldg_checker.sv -----
module ldg_checker
   import ldg_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [DENSITY_W-1:0]  req_density,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DENSITY_W-1:0]  rsp_new_density,
   input logic [COL_W-1:0]      rsp_cell_x,
   input logic [ROW_W-1:0]      rsp_cell_y,
   input logic                  rsp_last_of_run,
   input logic                  csr_write_enable,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_write_data
);

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_density)
         && $stable(rsp_cell_x) && $stable(rsp_cell_y) && $stable(rsp_last_of_run))
      else $error("rsp payload changed while stalled");

   // A beat that is not the last of its run is followed at once by the
   // border cell directly below it.
   a_run_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid && rsp_last_of_run
         && (rsp_cell_x == $past(rsp_cell_x)) && (rsp_cell_y == $past(rsp_cell_y) + 1'b1))
      else $error("second result of a run missing or misplaced");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("ports not quiet after reset");

   // The prefetch reloads after every register write.
   a_csr_reload: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> !req_ready)
      else $error("input taken before line buffer prefetch reloaded");

endmodule

bind laplacian_diffusion_grid ldg_checker u_ldg_checker (.*);

// ----- dv/laplacian_diffusion_grid_test.sv -----
module laplacian_diffusion_grid_test;
   import ldg_pkg::*;

   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_SAMPLES = 160;
   localparam int MAX_PRINTED    = 40;

   localparam int RX_ALWAYS   = 0;
   localparam int RX_RANDOM   = 1;
   localparam int RX_PERIODIC = 2;
   localparam int RX_LONG     = 3;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [DENSITY_W-1:0]  req_density      = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [DENSITY_W-1:0]  rsp_new_density;
   logic [COL_W-1:0]      rsp_cell_x;
   logic [ROW_W-1:0]      rsp_cell_y;
   logic                  rsp_last_of_run;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   laplacian_diffusion_grid dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_density      (req_density),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_new_density  (rsp_new_density),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the grid state and the registers.
   logic [GAIN_W-1:0]    gain_reg;
   logic [SIZE_W-1:0]    width_reg;
   logic [SIZE_W-1:0]    height_reg;
   logic [DENSITY_W-1:0] line_above [MAX_WIDTH];
   logic [DENSITY_W-1:0] line_two_above [MAX_WIDTH];
   logic [DENSITY_W-1:0] left_cell;
   int                   pos_col;
   int                   pos_row;

   result_type           pending_cells [$];
   int                   error_count;
   int                   samples_accepted;
   logic [DENSITY_W-1:0] last_density;

   int                   burst_left;
   bit                   gaps_on;

   int                   rx_mode;
   int                   rx_phase;
   int                   rx_stall;
   int                   idle_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTED)
         $display("ERROR: %s", msg);
      error_count++;
   endtask

   function automatic int eff_size(input logic [SIZE_W-1:0] v, input int hi);
      if (v < SIZE_MIN)
         return SIZE_MIN;
      if (v > hi)
         return hi;
      return v;
   endfunction

   function automatic logic [DENSITY_W-1:0] diffuse_cell(
      input logic [DENSITY_W-1:0] c, l, r, u, d);
      longint lap;
      longint t;
      longint v;
      lap = longint'(l) + longint'(r) + longint'(u) + longint'(d) - 4 * longint'(c);
      t = lap * longint'(gain_reg) + 32768;
      // Arithmetic shift floors, which together with the bias rounds half up.
      v = longint'(c) + (t >>> 16);
      if (v < 0)
         v = 0;
      if (v > 65535)
         v = 65535;
      return v[DENSITY_W-1:0];
   endfunction

   task automatic add_expected(input result_type r);
      pending_cells = {pending_cells, r};
   endtask

   task automatic predict_diffusion(input logic [DENSITY_W-1:0] d);
      int                   w;
      int                   h;
      int                   x;
      int                   y;
      logic [DENSITY_W-1:0] centre;
      logic [DENSITY_W-1:0] val;
      bit                   last_row;
      result_type           beat;
      w = eff_size(width_reg, MAX_WIDTH);
      h = eff_size(height_reg, MAX_HEIGHT);
      if (pos_col >= w)
         pos_col = 0;
      if (pos_row >= h)
         pos_row = 0;
      x = pos_col;
      y = pos_row;
      centre = line_above[COL_W'(x)];
      if (y >= 1) begin
         val = centre;
         last_row = (y == h - 1);
         if (y - 1 != 0 && x != 0 && x != w - 1)
            val = diffuse_cell(centre, left_cell, line_above[COL_W'(x + 1)],
                               line_two_above[COL_W'(x)], d);
         beat.new_density = val;
         beat.cell_x      = COL_W'(x);
         beat.cell_y      = ROW_W'(y - 1);
         beat.last_of_run = !last_row;
         add_expected(beat);
         if (last_row) begin
            beat.new_density = d;
            beat.cell_x      = COL_W'(x);
            beat.cell_y      = ROW_W'(y);
            beat.last_of_run = 1'b1;
            add_expected(beat);
         end
      end
      left_cell                  = centre;
      line_two_above[COL_W'(x)] = centre;
      line_above[COL_W'(x)]     = d;
      if (x + 1 >= w) begin
         pos_col = 0;
         pos_row = (y + 1 >= h) ? 0 : y + 1;
      end else begin
         pos_col = x + 1;
      end
   endtask

   function automatic int samples_to_frame_end();
      int w;
      int h;
      int c;
      int r;
      w = eff_size(width_reg, MAX_WIDTH);
      h = eff_size(height_reg, MAX_HEIGHT);
      c = (pos_col >= w) ? 0 : pos_col;
      r = (pos_row >= h) ? 0 : pos_row;
      return (h - 1 - r) * w + (w - c);
   endfunction

   function automatic logic [DENSITY_W-1:0] pick_density();
      logic [DENSITY_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2, 3: v = last_density + DENSITY_W'($urandom_range(0, 64)) - DENSITY_W'(32);
         default: v = DENSITY_W'($urandom);
      endcase
      last_density = v;
      return v;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return CSR_DATA_W'($urandom_range(0, 255));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_size(input int limit);
      logic [CSR_DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = CSR_DATA_W'($urandom_range(0, 2));
         1: v = CSR_DATA_W'($urandom_range(25, 80));
         default: v = CSR_DATA_W'($urandom_range(3, limit));
      endcase
      // Bits above the register width are ignored by the block.
      if ($urandom_range(0, 3) == 0)
         v[CSR_DATA_W-1:SIZE_W] = (CSR_DATA_W-SIZE_W)'($urandom);
      return v;
   endfunction

   task automatic send_sample(input logic [DENSITY_W-1:0] d);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = gaps_on ? $urandom_range(0, 16) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_density <= d;
      @(posedge clock);
      while (req_ready !== 1'b1)
         @(posedge clock);
      samples_accepted++;
      predict_diffusion(d);
   endtask

   task automatic send_samples(input int n);
      repeat (n) send_sample(pick_density());
   endtask

   task automatic send_to_frame_end();
      send_samples(samples_to_frame_end());
   endtask

   // Registers change only with no result outstanding and the pipeline settled.
   task automatic go_idle();
      req_valid <= 1'b0;
      while (pending_cells.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_DIFFUSION_GAIN: gain_reg = data[GAIN_W-1:0];
         CSR_GRID_WIDTH:     width_reg = data[SIZE_W-1:0];
         CSR_GRID_HEIGHT:    height_reg = data[SIZE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_grid_3x3(input logic [DENSITY_W-1:0] edge_val,
                                input logic [DENSITY_W-1:0] mid_val);
      for (int i = 0; i < 9; i++)
         send_sample((i == 4) ? mid_val : edge_val);
   endtask

   // Two rows and a few samples at the reset size, then a height cut that
   // makes the current row the last one of the frame.
   task automatic test_reset_defaults();
      gaps_on = 1'b1;
      send_samples(2 * 64 + 8);
      go_idle();
      write_register(CSR_GRID_HEIGHT, 16'd3);
      send_to_frame_end();
   endtask

   task automatic test_clamp_and_rounding();
      go_idle();
      write_register(CSR_DIFFUSION_GAIN, 16'hFFFF);
      write_register(CSR_GRID_WIDTH, 16'hF800);
      write_register(CSR_GRID_HEIGHT, 16'd2);
      // A bright centre in a dark grid undershoots and clamps at zero.
      send_grid_3x3(16'h0000, 16'hFFFF);
      // A dark centre in a bright grid overshoots and clamps at full scale.
      send_grid_3x3(16'hFFFF, 16'h0000);
      go_idle();
      write_register(CSR_DIFFUSION_GAIN, 16'h8000);
      // A Laplacian of one at half gain lands exactly on the rounding midpoint.
      for (int i = 0; i < 9; i++)
         send_sample((i == 3) ? 16'd101 : 16'd100);
   endtask

   task automatic test_mid_frame_resize();
      go_idle();
      write_register(CSR_DIFFUSION_GAIN, pick_gain());
      write_register(CSR_GRID_WIDTH, 16'd12);
      write_register(CSR_GRID_HEIGHT, 16'd8);
      send_samples(3 * 12 + 5);
      go_idle();
      // The column is past the new width, so the row starts over at column 0.
      write_register(CSR_GRID_WIDTH, 16'd4);
      send_to_frame_end();
      go_idle();
      write_register(CSR_GRID_HEIGHT, 16'd3);
      send_samples(2 * 4 + 2);
      go_idle();
      write_register(CSR_GRID_HEIGHT, 16'd6);
      send_to_frame_end();
      go_idle();
      send_samples(4 * 4 + 1);
      go_idle();
      write_register(CSR_GRID_HEIGHT, 16'd4);
      send_to_frame_end();
   endtask

   task automatic test_size_limits();
      go_idle();
      gaps_on = 1'b0;
      write_register(CSR_GRID_WIDTH, 16'h07FF);
      write_register(CSR_GRID_HEIGHT, 16'd3);
      // One full row at the widest size shows where the row wraps.
      send_samples(MAX_WIDTH + 4);
      go_idle();
      gaps_on = 1'b1;
      write_register(CSR_GRID_WIDTH, 16'd3);
      send_to_frame_end();
      go_idle();
      // The tallest size must not end the frame early.
      write_register(CSR_GRID_HEIGHT, 16'h07FF);
      send_samples(4 * 3);
      go_idle();
      write_register(CSR_GRID_HEIGHT, 16'd3);
      send_to_frame_end();
   endtask

   task automatic run_random_frame();
      int w;
      int h;
      go_idle();
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1))
         write_register(CSR_DIFFUSION_GAIN, pick_gain());
      if ($urandom_range(0, 1))
         write_register(CSR_GRID_WIDTH, pick_size(24));
      if ($urandom_range(0, 1))
         write_register(CSR_GRID_HEIGHT, pick_size(10));
      w = eff_size(width_reg, MAX_WIDTH);
      h = eff_size(height_reg, MAX_HEIGHT);
      // Resizing only after two full rows keeps every buffer read on written data.
      if (h >= 4 && $urandom_range(0, 3) == 0) begin
         send_samples(2 * w + $urandom_range(0, w * (h - 2) - 1));
         go_idle();
         case ($urandom_range(0, 2))
            0: write_register(CSR_DIFFUSION_GAIN, pick_gain());
            1: begin
               if (w > 3)
                  write_register(CSR_GRID_WIDTH, CSR_DATA_W'($urandom_range(3, w - 1)));
               else
                  write_register(CSR_DIFFUSION_GAIN, pick_gain());
            end
            default: write_register(CSR_GRID_HEIGHT, CSR_DATA_W'($urandom_range(3, h + 6)));
         endcase
      end
      send_to_frame_end();
   endtask

   task automatic test_random_frames();
      int start;
      start = samples_accepted;
      while (samples_accepted - start < RANDOM_SAMPLES)
         run_random_frame();
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_cells.size() == 0) begin
            report_error($sformatf("unexpected beat for cell (%0d,%0d)",
                                   rsp_cell_x, rsp_cell_y));
         end else begin
            want = pending_cells.pop_front();
            if (rsp_new_density !== want.new_density)
               report_error($sformatf("cell (%0d,%0d) new_density %h, want %h",
                                      want.cell_x, want.cell_y,
                                      rsp_new_density, want.new_density));
            if (rsp_cell_x !== want.cell_x)
               report_error($sformatf("cell_x %0d, want %0d", rsp_cell_x, want.cell_x));
            if (rsp_cell_y !== want.cell_y)
               report_error($sformatf("cell_y %0d, want %0d", rsp_cell_y, want.cell_y));
            if (rsp_last_of_run !== want.last_of_run)
               report_error($sformatf("cell (%0d,%0d) last_of_run %b, want %b",
                                      want.cell_x, want.cell_y,
                                      rsp_last_of_run, want.last_of_run));
         end
      end
   end

   // The result side switches between stall patterns at random.
   always @(posedge clock) begin
      if (rx_phase == 0) begin
         rx_mode  = $urandom_range(RX_ALWAYS, RX_LONG);
         rx_phase = $urandom_range(64, 512);
      end
      rx_phase--;
      case (rx_mode)
         RX_ALWAYS:   rsp_ready <= 1'b1;
         RX_RANDOM:   rsp_ready <= ($urandom_range(0, 9) >= 3);
         RX_PERIODIC: rsp_ready <= ((rx_phase % 8) >= 3);
         default: begin
            if (rx_stall == 0 && $urandom_range(0, 15) == 0)
               rx_stall = $urandom_range(5, 40);
            if (rx_stall > 0) begin
               rx_stall--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      gain_reg         = GAIN_RESET;
      width_reg        = WIDTH_RESET;
      height_reg       = HEIGHT_RESET;
      left_cell        = '0;
      pos_col          = 0;
      pos_row          = 0;
      error_count      = 0;
      samples_accepted = 0;
      last_density     = '0;
      burst_left       = 0;
      gaps_on          = 1'b1;
      rx_mode          = RX_ALWAYS;
      rx_phase         = 0;
      rx_stall         = 0;
      idle_cycles      = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_above[COL_W'(i)]     = '0;
         line_two_above[COL_W'(i)] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_clamp_and_rounding();
      test_mid_frame_resize();
      test_size_limits();
      test_random_frames();
      go_idle();
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
